### rtl/sha256_pkg.sv
// Shared types, constants and a rotate helper for the SHA-256 byte stream hasher.
package sha256_pkg;

  localparam int unsigned WordW = 32;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       store_byte;
    logic [7:0] byte_val;
    logic       count_byte;
    logic       pad_step;
    logic       load_sched;
    logic       round_step;
    logic       fold;
    logic       restart;
    logic       clear_fill;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [6:0] fill;
  } dp_stat_t;

  localparam logic [7:0] PadMarker = 8'h80;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (WordW - n));
  endfunction

endpackage

### rtl/sha256_dp.sv
// Datapath: message schedule window (also the block buffer), round registers and chaining words.
module sha256_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  sha256_pkg::dp_cmd_t cmd,
  input  logic [5:0]          round_idx,
  output sha256_pkg::dp_stat_t stat,
  output logic [31:0]         hash_word [8]
);
  import sha256_pkg::*;

  logic [6:0]  fill_r, fill_nxt;
  logic [60:0] len_r, len_nxt;
  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [31:0] hv_r [8];
  logic [63:0] bits;
  logic [7:0]  pad_byte;
  logic [31:0] w_cur, w_new, t1, t2, s0, s1;

  assign stat.fill = fill_r;
  assign bits = {len_r, 3'b000};

  // Pick the padding byte for the current fill slot
  always_comb begin
    if (fill_r[5:0] >= 6'd56) begin
      pad_byte = 8'(bits >> (8 * (7 - 32'(fill_r[5:0] - 6'd56))));
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Next schedule word and round sums
  always_comb begin
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_new = w_r[0] + s0 + w_r[9] + s1;
    w_cur = w_r[0];
    t1 = h_r + (rotr(e_r, 6) ^ rotr(e_r, 11) ^ rotr(e_r, 25)) +
         ((e_r & f_r) ^ (~e_r & g_r)) + RoundK[round_idx] + w_cur;
    t2 = (rotr(a_r, 2) ^ rotr(a_r, 13) ^ rotr(a_r, 22)) +
         ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));
  end

  // Fill and length counters
  always_comb begin
    fill_nxt = fill_r;
    len_nxt  = len_r;
    if (cmd.store_byte || cmd.pad_step) fill_nxt = fill_r + 7'd1;
    if (cmd.count_byte) len_nxt = len_r + 61'd1;
    if (cmd.clear_fill) fill_nxt = '0;
    if (cmd.restart) begin
      fill_nxt = '0;
      len_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      len_r  <= '0;
      for (int i = 0; i < 8; i++) hv_r[i] <= InitH[i];
    end else begin
      fill_r <= fill_nxt;
      len_r  <= len_nxt;
      if (cmd.fold) begin
        hv_r[0] <= hv_r[0] + a_r; hv_r[1] <= hv_r[1] + b_r;
        hv_r[2] <= hv_r[2] + c_r; hv_r[3] <= hv_r[3] + d_r;
        hv_r[4] <= hv_r[4] + e_r; hv_r[5] <= hv_r[5] + f_r;
        hv_r[6] <= hv_r[6] + g_r; hv_r[7] <= hv_r[7] + h_r;
      end else if (cmd.restart) begin
        for (int i = 0; i < 8; i++) hv_r[i] <= InitH[i];
      end
    end
  end

  // Pack bytes big-endian into the schedule window; load a..h; per round shift one word, step a..h
  always_ff @(posedge clk) begin
    if (cmd.load_sched) begin
      a_r <= hv_r[0]; b_r <= hv_r[1]; c_r <= hv_r[2]; d_r <= hv_r[3];
      e_r <= hv_r[4]; f_r <= hv_r[5]; g_r <= hv_r[6]; h_r <= hv_r[7];
    end else if (cmd.round_step) begin
      for (int t = 0; t < 15; t++) w_r[t] <= w_r[t+1];
      w_r[15] <= w_new;
      h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
    end else if (cmd.store_byte) begin
      w_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= cmd.byte_val;
    end else if (cmd.pad_step) begin
      w_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= pad_byte;
    end
  end

  assign hash_word = hv_r;
endmodule

### rtl/sha256_ctrl.sv
// Controller: sequences byte fill, padding, compression rounds and digest output.
module sha256_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic [7:0]           in_byte,
  input  logic                 in_has,
  input  logic                 in_end,
  input  logic                 out_fire,
  input  sha256_pkg::dp_stat_t stat,
  output logic                 in_rdy,
  output logic                 out_vld,
  output logic [2:0]           out_idx,
  output logic [5:0]           round_idx,
  output sha256_pkg::dp_cmd_t  cmd
);
  import sha256_pkg::*;

  ctrl_state_t st_r, st_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        fin_r, fin_nxt;   // message ended: padding still due
  logic        mark_r, mark_nxt; // pad marker already written
  logic        last_r, last_nxt; // block in flight is the final one

  assign round_idx = rnd_r;
  assign out_idx   = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_FILL; rnd_r <= '0; idx_r <= '0; fin_r <= 1'b0; last_r <= 1'b0;
      mark_r <= 1'b0;
    end else begin
      st_r <= st_nxt; rnd_r <= rnd_nxt; idx_r <= idx_nxt;
      fin_r <= fin_nxt; last_r <= last_nxt; mark_r <= mark_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r; rnd_nxt = rnd_r; idx_nxt = idx_r;
    fin_nxt = fin_r; last_nxt = last_r; mark_nxt = mark_r;
    cmd = '0;
    cmd.byte_val = in_byte;
    in_rdy = 1'b0;
    out_vld = 1'b0;
    case (st_r)
      ST_FILL: begin
        in_rdy = 1'b1;
        if (in_fire) begin
          cmd.store_byte = in_has;
          cmd.count_byte = in_has;
          if (in_has && stat.fill == 7'd63) begin
            fin_nxt = in_end; last_nxt = 1'b0;
            st_nxt = ST_LOAD;
          end else if (in_end) begin
            fin_nxt = 1'b1;
            st_nxt = ST_PAD;
          end
        end
      end
      // First pad cycle writes the marker, then zeros, and the length in the final block
      ST_PAD: begin
        if (!mark_r) begin
          cmd.store_byte = 1'b1;
          cmd.byte_val = PadMarker;
          mark_nxt = 1'b1;
          last_nxt = (stat.fill < 7'd56);
        end else if (last_r && stat.fill >= 7'd56) begin
          cmd.pad_step = 1'b1;
        end else begin
          cmd.store_byte = 1'b1;
          cmd.byte_val = 8'h00;
        end
        if (stat.fill == 7'd63) st_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load_sched = 1'b1;
        cmd.clear_fill = 1'b1;
        rnd_nxt = '0;
        st_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) st_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (last_r) begin
          idx_nxt = '0; st_nxt = ST_EMIT;
        end else if (fin_r) begin
          last_nxt = 1'b1; st_nxt = ST_PAD;
        end else begin
          st_nxt = ST_FILL;
        end
      end
      ST_EMIT: begin
        out_vld = 1'b1;
        if (out_fire) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            cmd.restart = 1'b1;
            fin_nxt = 1'b0; last_nxt = 1'b0; mark_nxt = 1'b0;
            st_nxt = ST_FILL;
          end
        end
      end
      default: st_nxt = ST_FILL;
    endcase
  end
endmodule

### rtl/sha256_byte_stream_hasher_unit.sv
// Top level of the SHA-256 byte stream hasher: stream ports, controller and datapath.
// Input: bytes are taken one per cycle while the block fills; no byte is taken while a block
// is processed. A full block is loaded, run through 64 rounds at one per cycle in the datapath,
// then folded into the chaining words. End of message: each padded block fills its free slots
// at one byte per cycle (up to 64), then is loaded, compressed and folded; one or two such
// blocks, then 8 result words.
// Reset: synchronous active-low rst_n restores the initial hash values and empty counts.
module sha256_byte_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_message
  input  logic        in_tuser,   // has_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        out_tlast   // last_word
);
  import sha256_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [5:0]  round_idx;
  logic [2:0]  out_idx;
  logic [31:0] hash_word [8];
  logic        in_fire, out_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  sha256_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_byte(in_tdata),
    .in_has(in_tuser), .in_end(in_tlast), .out_fire(out_fire), .stat(stat),
    .in_rdy(in_tready), .out_vld(out_tvalid), .out_idx(out_idx),
    .round_idx(round_idx), .cmd(cmd));

  sha256_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .round_idx(round_idx),
    .stat(stat), .hash_word(hash_word));

  assign out_tdata = {5'd0, out_idx, hash_word[out_idx]};
  assign out_tlast = (out_idx == 3'd7);

  // Never take input while the digest is being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input taken during digest output");

  // The last digest word returns the block to byte fill
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_tlast |=> in_tready) else $error("no restart after digest");

  // Fill count never exceeds one block
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    stat.fill <= 7'd64) else $error("fill count overflow");
endmodule

### test/tb.sv
// SHA-256 byte stream hasher testbench: directed and random streams checked against a built-in digest model.
`timescale 1ns / 1ps

class digest_board;
  logic [31:0] hash_w [8];
  logic [7:0]  blk [64];
  int unsigned fill;
  logic [60:0] msg_len;
  logic [31:0] want_word [$];
  logic [2:0]  want_idx [$];
  logic        want_last [$];
  int unsigned errors;
  int unsigned words_seen;
  int unsigned digests;

  function new();
    errors = 0;
    words_seen = 0;
    digests = 0;
    restart();
  endfunction

  function void restart();
    for (int i = 0; i < 8; i++) hash_w[i] = sha256_pkg::InitH[i];
    fill = 0;
    msg_len = '0;
  endfunction

  function logic [31:0] ror(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // Run one 64-round compression over the block buffer
  function void compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    a = hash_w[0]; b = hash_w[1]; c = hash_w[2]; d = hash_w[3];
    e = hash_w[4]; f = hash_w[5]; g = hash_w[6]; h = hash_w[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
           + sha256_pkg::RoundK[t] + w[t];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_w[0] += a; hash_w[1] += b; hash_w[2] += c; hash_w[3] += d;
    hash_w[4] += e; hash_w[5] += f; hash_w[6] += g; hash_w[7] += h;
  endfunction

  // Note an accepted request and queue any digest words it produces
  function void note_request(logic [7:0] data, logic has, logic fin);
    logic [63:0] bits;
    if (has) begin
      blk[fill] = data;
      fill++;
      msg_len++;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    end
    if (!fin) return;
    bits = {msg_len, 3'b000};
    blk[fill] = sha256_pkg::PadMarker;
    fill++;
    if (fill > 56) begin
      while (fill < 64) begin blk[fill] = 8'h00; fill++; end
      compress();
      fill = 0;
    end
    while (fill < 56) begin blk[fill] = 8'h00; fill++; end
    for (int i = 0; i < 8; i++) blk[56+i] = bits[63-8*i -: 8];
    compress();
    for (int i = 0; i < 8; i++) begin
      want_word.push_back(hash_w[i]);
      want_idx.push_back(3'(i));
      want_last.push_back(i == 7);
    end
    digests++;
    restart();
  endfunction

  // Compare one digest word with the oldest expectation
  function void check_word(logic [39:0] tdata, logic tlast);
    logic [31:0] ew;
    logic [2:0]  ei;
    logic        el;
    words_seen++;
    if (want_word.size() == 0) begin
      $display("%0t: unexpected word %h last %b", $time, tdata, tlast);
      errors++;
      return;
    end
    ew = want_word.pop_front();
    ei = want_idx.pop_front();
    el = want_last.pop_front();
    if (tdata[31:0] !== ew) begin
      $display("%0t: digest_word expected %h actual %h", $time, ew, tdata[31:0]);
      errors++;
    end
    if (tdata[34:32] !== ei) begin
      $display("%0t: word_index expected %0d actual %0d", $time, ei, tdata[34:32]);
      errors++;
    end
    if (tlast !== el) begin
      $display("%0t: last_word expected %b actual %b", $time, el, tlast);
      errors++;
    end
    if (tdata[39:35] !== 5'b0) begin
      $display("%0t: pad bits expected 0 actual %h", $time, tdata[39:35]);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return want_word.size();
  endfunction
endclass

module tb;
  localparam int unsigned IdleLimit = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;

  digest_board board;
  int unsigned idle_cycles;
  int unsigned requests;
  bit          stim_done;

  sha256_byte_stream_hasher_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Send one request after a random gap, hold until accepted; returns at a falling edge
  task automatic send_byte(logic [7:0] data, logic has, logic fin);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= has;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_request(data, has, fin);
    requests++;
    @(negedge clk);
  endtask

  // Drop the request line; called at a falling edge
  task automatic idle_input();
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  // Send a whole message of len bytes of random content
  task automatic send_message(int len);
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom), 1'b1, i == len - 1);
    if (len == 0) send_byte(8'($urandom), 1'b0, 1'b1);
  endtask

  // Receiver: random stalls, check on accept
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      int stall;
      @(negedge clk);
      stall = $urandom_range(0, 5);
      if (stall > 0 && $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      board.check_word(out_tdata, out_tlast);
    end
  end

  // Watchdog: count cycles without any input or output handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int lens [];
    int wait_cycles;
    lens = '{0, 1, 55, 56, 63, 64};
    board = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tlast = 1'b0;
    in_tuser = 1'b0;
    requests = 0;
    stim_done = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes of byte values, empty item, empty message, message abc
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hff, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hff, 1'b0, 1'b0);
    send_byte(8'hff, 1'b1, 1'b1);
    send_byte(8'h61, 1'b1, 1'b0);
    send_byte(8'h62, 1'b1, 1'b0);
    send_byte(8'h63, 1'b1, 1'b1);

    // Hold off until every digest word is back
    idle_input();
    while (board.pending() != 0) @(negedge clk);

    // Padding boundaries: marker in the last slot, extra block, full block at the end
    foreach (lens[i]) send_message(lens[i]);

    // A few short random messages with noise items mixed in
    for (int m = 0; m < 4; m++) begin
      int len;
      len = $urandom_range(0, 3);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0) send_byte(8'($urandom), 1'b0, 1'b0);
        send_byte(8'($urandom), 1'b1, i == len - 1);
      end
      if (len == 0) send_byte(8'($urandom), 1'b0, 1'b1);
    end

    // Drain
    idle_input();
    stim_done = 1;
    wait_cycles = 0;
    while (board.pending() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (300) @(posedge clk);
    $display("Covered %0d requests, %0d digests, %0d digest words checked.",
             requests, board.digests, board.words_seen);
    if (board.errors == 0 && board.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
